FILE: design/cr_pkg.sv
// Shared types and constants for the circle rasterizer.
// No dependencies; imported by every module of the block.
package cr_pkg;

    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 12;
    localparam int ERR_W    = 16;
    localparam int COLOR_W  = 16;

    localparam int DEFAULT_MAX_RADIUS = 4095;
    localparam int DEFAULT_JOB_DEPTH  = 4;

    // Midpoint decision constants
    localparam logic [ERR_W-1:0] ERR_BASE    = 16'd3;
    localparam logic [ERR_W-1:0] ERR_INC_NEG = 16'd6;
    localparam logic [ERR_W-1:0] ERR_INC_POS = 16'd10;

    // Eight mirrored pixels per position
    localparam int PIX_IDX_W = 3;
    localparam logic [PIX_IDX_W-1:0] LAST_PIXEL = 3'd7;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    // One position handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [RADIUS_W-1:0] x;
        logic [RADIUS_W-1:0] s;
        logic                done;
    } t_job;

endpackage

FILE: design/circle_rasterizer.sv
// Top level of the circle rasterizer: front end, job queue, pixel back end.
// Depends on cr_pkg, cr_front, cr_job_fifo, cr_back.
//
// Midpoint circle rasterizer with eight-way mirroring. A start item (op 0)
// loads centre, radius (clamped to MAX_RADIUS) and outline/filled mode and
// produces no pixels. Each advance item (op 1) produces eight pixel items in
// the paint color; last_of_step marks the eighth, and figure_done is set on
// all eight of the advance that completes the circle. Advances with no figure
// in progress are taken and dropped. The front end takes one item per cycle
// while the queue is not full and pushes one job per advance into a
// JOB_DEPTH-entry queue; the back end emits one pixel per cycle while pop
// keeps up, so sustained throughput is set by the single pixel output.
// Pixels pass through the job queue and the back-end output register. full
// follows the job queue. Write paint_color only when the block has drained.
module circle_rasterizer import cr_pkg::*; #(
    parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS,
    parameter int JOB_DEPTH  = DEFAULT_JOB_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic                i_op,
    input  logic [COORD_W-1:0]  i_center_x,
    input  logic [COORD_W-1:0]  i_center_y,
    input  logic [RADIUS_W-1:0] i_radius,
    input  logic                i_filled,
    input  logic                i_cfg_we,
    input  logic [COLOR_W-1:0]  i_cfg_data,
    output logic                empty,
    input  logic                pop,
    output logic [COORD_W-1:0]  o_pixel_x,
    output logic [COORD_W-1:0]  o_pixel_y,
    output logic [COLOR_W-1:0]  o_color,
    output logic                o_last_of_step,
    output logic                o_figure_done
);

    logic [COLOR_W-1:0] r_paint_color;
    logic               accept;
    logic               job_push, job_pop, job_full, job_empty;
    t_job               job_in, job_head;

    // paint color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paint_color <= '0;
        end else if (i_cfg_we) begin
            r_paint_color <= i_cfg_data;
        end
    end

    assign full   = job_full;
    assign accept = push && !job_full;

    cr_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (i_op),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_filled   (i_filled),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    cr_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_full  (job_full),
        .o_empty (job_empty)
    );

    cr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job_head),
        .i_job_empty    (job_empty),
        .o_job_pop      (job_pop),
        .i_color        (r_paint_color),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_color        (o_color),
        .o_last_of_step (o_last_of_step),
        .o_figure_done  (o_figure_done)
    );

endmodule

FILE: design/cr_front.sv
// Front end: takes items, holds the circle stepping state, and emits one job
// per advance taken while a figure is in progress. Depends on cr_pkg.
module cr_front import cr_pkg::*; #(
    parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_op,
    input  logic [COORD_W-1:0]  i_center_x,
    input  logic [COORD_W-1:0]  i_center_y,
    input  logic [RADIUS_W-1:0] i_radius,
    input  logic                i_filled,
    output logic                o_job_push,
    output t_job                o_job
);

    localparam logic [RADIUS_W-1:0] MAX_R = RADIUS_W'(MAX_RADIUS);

    logic [COORD_W-1:0]  r_cx, n_cx;
    logic [COORD_W-1:0]  r_cy, n_cy;
    logic [RADIUS_W-1:0] r_step_x, n_step_x;
    logic [RADIUS_W-1:0] r_step_y, n_step_y;
    logic [ERR_W-1:0]    r_err, n_err;
    logic [RADIUS_W-1:0] r_span, n_span;
    logic                r_fill, n_fill;
    logic                r_busy, n_busy;

    logic [RADIUS_W-1:0]   radius_c;
    logic [RADIUS_W:0]     x_inc;
    logic signed [RADIUS_W+1:0] xs, ys;
    logic [ERR_W-1:0]      x4, y4, err_step;
    logic [RADIUS_W-1:0]   s_val;
    logic                  do_step, step_done, advance;

    always_comb begin
        radius_c = (i_radius > MAX_R) ? MAX_R : i_radius;
        x_inc    = {1'b0, r_step_x} + {{RADIUS_W{1'b0}}, 1'b1};
        x4       = ERR_W'({x_inc, 2'b00});
        y4       = ERR_W'({r_step_y, 2'b00});
        xs       = signed'({1'b0, x_inc});
        if (r_err[ERR_W-1]) begin
            err_step = r_err + x4 + ERR_INC_NEG;
            ys       = signed'({2'b00, r_step_y});
        end else begin
            err_step = r_err + ERR_INC_POS + x4 - y4;
            ys       = signed'({2'b00, r_step_y}) - 14'sd1;
        end
        step_done = xs > ys;
        // filled mode walks the span rows before taking the next circle step
        do_step   = !(r_fill && (r_span < r_step_y));
        s_val     = r_fill ? r_span : r_step_y;
        advance   = i_accept && (i_op == OP_ADVANCE) && r_busy;

        n_cx     = r_cx;
        n_cy     = r_cy;
        n_step_x = r_step_x;
        n_step_y = r_step_y;
        n_err    = r_err;
        n_span   = r_span;
        n_fill   = r_fill;
        n_busy   = r_busy;

        if (i_accept && (i_op == OP_START)) begin
            n_cx     = i_center_x;
            n_cy     = i_center_y;
            n_fill   = i_filled;
            n_step_x = '0;
            n_step_y = radius_c;
            n_err    = ERR_BASE - ERR_W'({radius_c, 1'b0});
            n_span   = '0;
            n_busy   = 1'b1;
        end else if (advance) begin
            if (do_step) begin
                n_step_x = x_inc[RADIUS_W-1:0];
                n_step_y = ys[RADIUS_W-1:0];
                n_err    = err_step;
                n_span   = x_inc[RADIUS_W-1:0];
                if (step_done) begin
                    n_busy = 1'b0;
                end
            end else begin
                n_span = r_span + {{(RADIUS_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_comb begin
        o_job_push = advance;
        o_job.cx   = r_cx;
        o_job.cy   = r_cy;
        o_job.x    = r_step_x;
        o_job.s    = s_val;
        o_job.done = do_step && step_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_step_x <= '0;
            r_step_y <= '0;
            r_err    <= '0;
            r_span   <= '0;
            r_fill   <= 1'b0;
            r_busy   <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_step_x <= n_step_x;
            r_step_y <= n_step_y;
            r_err    <= n_err;
            r_span   <= n_span;
            r_fill   <= n_fill;
            r_busy   <= n_busy;
        end
    end

endmodule

FILE: design/cr_job_fifo.sv
// Short job queue between front and back ends.
// Depends on cr_pkg (t_job).
module cr_job_fifo import cr_pkg::*; #(
    parameter int DEPTH = DEFAULT_JOB_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    always_comb begin
        o_full   = (r_count == CNT_W'(DEPTH));
        o_empty  = (r_count == '0);
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
        o_data = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: design/cr_back.sv
// Back end: walks the eight mirrored pixels of the head job into an output
// register. Depends on cr_pkg.
module cr_back import cr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_job,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    input  logic [COLOR_W-1:0] i_color,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic [COLOR_W-1:0] o_color,
    output logic               o_last_of_step,
    output logic               o_figure_done
);

    logic [PIX_IDX_W-1:0] r_k;
    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_px, r_py;
    logic [COLOR_W-1:0]   r_color;
    logic                 r_last, r_done;

    logic [COORD_W-1:0]   x16, s16, px_p, px_m, ps_p, ps_m, py_p, py_m, qs_p, qs_m;
    logic [COORD_W-1:0]   n_px, n_py;
    logic                 load;

    always_comb begin
        x16  = COORD_W'(i_job.x);
        s16  = COORD_W'(i_job.s);
        px_p = i_job.cx + x16;
        px_m = i_job.cx - x16;
        ps_p = i_job.cx + s16;
        ps_m = i_job.cx - s16;
        py_p = i_job.cy + x16;
        py_m = i_job.cy - x16;
        qs_p = i_job.cy + s16;
        qs_m = i_job.cy - s16;
        unique case (r_k)
            3'd0:    begin n_px = px_p; n_py = qs_p; end
            3'd1:    begin n_px = px_m; n_py = qs_p; end
            3'd2:    begin n_px = ps_m; n_py = py_p; end
            3'd3:    begin n_px = ps_m; n_py = py_m; end
            3'd4:    begin n_px = px_m; n_py = qs_m; end
            3'd5:    begin n_px = px_p; n_py = qs_m; end
            3'd6:    begin n_px = ps_p; n_py = py_m; end
            default: begin n_px = ps_p; n_py = py_p; end
        endcase
        load      = !i_job_empty && (!r_out_valid || i_pop);
        o_job_pop = load && (r_k == LAST_PIXEL);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_color <= i_color;
            r_last  <= (r_k == LAST_PIXEL);
            r_done  <= i_job.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k         <= r_k + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_color        = r_color;
    assign o_last_of_step = r_last;
    assign o_figure_done  = r_done;

endmodule
